### hdl/deq_pkg.sv
// shared types, operation and status codes for the double-ended queue
package deq_pkg;

  // default geometry
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed widths of the beat fields
  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int ELEM_W   = 32;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_LIST_FWD   = 3'd4;
  localparam logic [OP_W-1:0] OP_LIST_BWD   = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;
  } op_beat_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic [STATUS_W-1:0]      status;
    logic                     last;
  } result_beat_t;

  // result under way between the control stage and the output register
  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic                last;
    logic                from_mem;
  } rsp_t;

endpackage

### hdl/deq_ram.sv
// ring store: one write port and one registered read port
module deq_ram
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int IDX_W     = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [IDX_W-1:0]      waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [IDX_W-1:0]      raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/deq_ctrl.sv
// command register, ring pointers and per-operation control
module deq_ctrl
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int IDX_W     = $clog2(DEPTH),
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  op_valid,
  output logic                  op_stall,
  input  op_beat_t              op_data,
  input  logic                  advance,
  output rsp_t                  rsp,
  output logic                  we,
  output logic [IDX_W-1:0]      waddr,
  output logic [DATA_WIDTH-1:0] wdata,
  output logic                  re,
  output logic [IDX_W-1:0]      raddr
);

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
  localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(DEPTH);

  logic             cmd_valid;
  op_beat_t         cmd;
  logic [IDX_W-1:0] front, front_next;
  logic [CNT_W-1:0] occ, occ_next;
  logic [IDX_W-1:0] list_i, list_i_next;
  rsp_t             rsp_next;
  logic             consume;
  logic             empty, full;
  logic [CNT_W-1:0] off;
  logic [IDX_W:0]   sum;
  logic [IDX_W-1:0] pos;
  logic [CNT_W-1:0] occ_m1;
  logic             list_last;

  assign empty     = (occ == '0);
  assign full      = (occ == FULL_CNT);
  assign occ_m1    = occ - CNT_W'(1);
  assign list_last = (CNT_W'(list_i) == occ_m1);

  generate
    if (DATA_WIDTH <= VALUE_W) begin : g_narrow
      assign wdata = cmd.value[DATA_WIDTH-1:0];
    end else begin : g_wide
      assign wdata = {{(DATA_WIDTH - VALUE_W){1'b0}}, cmd.value};
    end
  endgenerate

  // offset from the front for the addressed entry
  always_comb begin
    case (cmd.operation)
      OP_PUSH_BACK: off = occ;
      OP_POP_BACK:  off = occ_m1;
      OP_LIST_FWD:  off = CNT_W'(list_i);
      OP_LIST_BWD:  off = occ_m1 - CNT_W'(list_i);
      default:      off = '0;
    endcase
  end

  // front plus offset, wrapped once
  always_comb begin
    sum = (IDX_W + 1)'(front) + (IDX_W + 1)'(off);
    if (sum >= DEPTH_EXT) begin
      sum = sum - DEPTH_EXT;
    end
    pos = sum[IDX_W-1:0];
  end

  always_comb begin
    consume     = 1'b0;
    rsp_next    = '0;
    front_next  = front;
    occ_next    = occ;
    list_i_next = list_i;
    we          = 1'b0;
    waddr       = pos;
    re          = 1'b0;
    raddr       = pos;
    if (cmd_valid && advance) begin
      case (cmd.operation)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          consume        = 1'b1;
          rsp_next.valid = 1'b1;
          rsp_next.last  = 1'b1;
          if (full) begin
            rsp_next.status = ST_FULL;
          end else begin
            rsp_next.status = ST_OK;
            we              = 1'b1;
            occ_next        = occ + CNT_W'(1);
            if (cmd.operation == OP_PUSH_FRONT) begin
              front_next = (front == '0) ? LAST_IDX : front - IDX_W'(1);
              waddr      = front_next;
            end
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          consume        = 1'b1;
          rsp_next.valid = 1'b1;
          rsp_next.last  = 1'b1;
          if (empty) begin
            rsp_next.status = ST_EMPTY;
          end else begin
            rsp_next.status   = ST_OK;
            rsp_next.from_mem = 1'b1;
            re                = 1'b1;
            occ_next          = occ_m1;
            if (cmd.operation == OP_POP_FRONT) begin
              raddr      = front;
              front_next = (front == LAST_IDX) ? '0 : front + IDX_W'(1);
            end
          end
        end
        OP_LIST_FWD, OP_LIST_BWD: begin
          rsp_next.valid = 1'b1;
          if (empty) begin
            consume         = 1'b1;
            rsp_next.status = ST_EMPTY;
            rsp_next.last   = 1'b1;
          end else begin
            rsp_next.status   = ST_OK;
            rsp_next.from_mem = 1'b1;
            rsp_next.last     = list_last;
            re                = 1'b1;
            if (list_last) begin
              consume     = 1'b1;
              list_i_next = '0;
            end else begin
              list_i_next = list_i + IDX_W'(1);
            end
          end
        end
        default: begin
          consume = 1'b1;
        end
      endcase
    end
  end

  assign op_stall = cmd_valid && !consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      front     <= '0;
      occ       <= '0;
      list_i    <= '0;
      rsp       <= '0;
    end else begin
      if (op_valid && !op_stall) begin
        cmd_valid <= 1'b1;
      end else if (consume) begin
        cmd_valid <= 1'b0;
      end
      front  <= front_next;
      occ    <= occ_next;
      list_i <= list_i_next;
      if (advance) begin
        rsp <= rsp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid && !op_stall) begin
      cmd <= op_data;
    end
  end

endmodule

### hdl/deq_out.sv
// output register; sign-extends the stored word when it is narrower than the element, else truncates it
module deq_out
  import deq_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rsp_t                  rsp,
  input  logic [DATA_WIDTH-1:0] rdata,
  output logic                  advance,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_beat_t          result_data
);

  logic signed [ELEM_W-1:0] widened;

  generate
    if (DATA_WIDTH >= ELEM_W) begin : g_trunc
      assign widened = rdata[ELEM_W-1:0];
    end else begin : g_sext
      assign widened = {{(ELEM_W - DATA_WIDTH){rdata[DATA_WIDTH-1]}}, rdata};
    end
  endgenerate

  // whole pipe moves when the output register is free or being taken
  assign advance = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= rsp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_data.element <= rsp.from_mem ? widened : '0;
      result_data.status  <= rsp.status;
      result_data.last    <= rsp.last;
    end
  end

endmodule

### hdl/double_ended_queue.sv
// double-ended queue top level: ring store in a synchronous ram with head index and count
// path: an accepted operation beat passes the command, response and output registers
// throughput: pushes and pops one per cycle unless the output stalls; a list gives
//   one beat per cycle per element likewise, the ram read port issued once per element
// reset: synchronous, clears head index, count and all valid flags; ram contents are kept
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         op_valid,
  output logic         op_stall,
  input  op_beat_t     op_data,
  output logic         result_valid,
  input  logic         result_stall,
  output result_beat_t result_data
);

  localparam int IDX_W = $clog2(DEPTH);

  // ram port signals
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  re;
  logic [IDX_W-1:0]      raddr;
  logic [DATA_WIDTH-1:0] rdata;

  // result under way, one stage ahead of the output register
  rsp_t rsp;
  // pipe-wide enable from the output side
  logic advance;

  // control: holds one operation beat, updates the ring pointers and issues
  // the ram access; a list stays in the command register, stepping one
  // element per cycle while the pipe advances, until its last beat
  deq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_stall (op_stall),
    .op_data  (op_data),
    .advance  (advance),
    .rsp      (rsp),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .re       (re),
    .raddr    (raddr)
  );

  // ring store; a read issued in one cycle is ready in the next, alongside the
  // matching result in the response register. a push and a later pop of
  // the same entry are handled in different cycles, so no forwarding is needed
  deq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // output register; while it is stalled the whole pipe holds, and the ram
  // read data holds with it since no new read is issued
  deq_out #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_out (
    .clk          (clk),
    .rst          (rst),
    .rsp          (rsp),
    .rdata        (rdata),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule
